/* hw/rtl/dsfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DLE STX frame receiver package
// Shared types, framing codes and sizes for the frame receiver blocks.
// ----------------------------------------------------------------------------
package dsfr_pkg;

  localparam int PAYLOAD_DEPTH = 64;
  localparam int LIMIT_W       = 7;
  localparam int BYTE_W        = 8;
  localparam int STATUS_W      = 3;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic [BYTE_W-1:0] CODE_DLE = 8'h10;
  localparam logic [BYTE_W-1:0] CODE_STX = 8'h02;
  localparam logic [BYTE_W-1:0] CODE_ETX = 8'h03;

  typedef enum logic [STATUS_W-1:0] {
    ST_DATA     = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_BAD_ESC  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_AWAIT_STX = 3'd1,
    PH_IN_FRAME  = 3'd2,
    PH_AFTER_DLE = 3'd3,
    PH_AWAIT_SUM = 3'd4
  } phase_t;

  typedef enum logic {
    EM_IDLE = 1'b0,
    EM_LOAD = 1'b1
  } emit_state_t;

  // Work handed from the parser to the emitter
  typedef struct packed {
    logic               is_burst;
    status_t            status;
    logic [LIMIT_W-1:0] count;
  } cmd_t;

endpackage

/* hw/rtl/dsfr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dsfr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/dsfr_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser
// Accepts received bytes, strips framing, stores payload, checks the
// checksum and posts one command per frame outcome.
// ----------------------------------------------------------------------------
module dsfr_parser #(
  parameter int PAYLOAD_DEPTH = dsfr_pkg::PAYLOAD_DEPTH,
  parameter int ADDR_W        = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1,
  parameter int CNT_W         = $clog2(PAYLOAD_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dsfr_pkg::BYTE_W-1:0]  rx_byte,
  input  logic [dsfr_pkg::LIMIT_W-1:0] payload_limit,
  input  logic                         q_full,
  output logic                         q_push,
  output dsfr_pkg::cmd_t               q_cmd,
  input  logic                         burst_done,
  output logic                         wr_en,
  output logic [ADDR_W-1:0]            wr_addr,
  output logic [dsfr_pkg::BYTE_W-1:0]  wr_data
);

  localparam logic [dsfr_pkg::LIMIT_W-1:0] DEPTH_L = dsfr_pkg::LIMIT_W'(PAYLOAD_DEPTH);

  dsfr_pkg::phase_t                phase, phase_next;
  logic [dsfr_pkg::BYTE_W-1:0]     checksum, checksum_next;
  logic [CNT_W-1:0]                count, count_next;
  logic                            burst_pending;
  logic                            accept;
  logic                            full;
  logic                            is_dle, is_stx, is_etx;
  logic [dsfr_pkg::LIMIT_W-1:0]    limit_eff;

  assign limit_eff = (payload_limit > DEPTH_L) ? DEPTH_L : payload_limit;
  assign full      = (dsfr_pkg::LIMIT_W'(count) >= limit_eff);
  assign is_dle    = (rx_byte == dsfr_pkg::CODE_DLE);
  assign is_stx    = (rx_byte == dsfr_pkg::CODE_STX);
  assign is_etx    = (rx_byte == dsfr_pkg::CODE_ETX);

  // Hold payload bytes while the previous frame is still being read out, and all bytes while the command queue is full
  assign in_ready = !q_full && !(burst_pending &&
                    (phase == dsfr_pkg::PH_IN_FRAME || phase == dsfr_pkg::PH_AFTER_DLE));
  assign accept   = in_valid && in_ready;

  // Next state
  always_comb begin
    phase_next    = phase;
    checksum_next = checksum;
    count_next    = count;
    if (accept) begin
      case (phase)
        dsfr_pkg::PH_AWAIT_STX: begin
          if (is_stx) begin
            count_next    = '0;
            checksum_next = '0;
            phase_next    = dsfr_pkg::PH_IN_FRAME;
          end else if (!is_dle) begin
            phase_next = dsfr_pkg::PH_IDLE;
          end
        end
        dsfr_pkg::PH_IN_FRAME: begin
          if (is_dle) begin
            phase_next = dsfr_pkg::PH_AFTER_DLE;
          end else if (full) begin
            phase_next    = dsfr_pkg::PH_IDLE;
            checksum_next = '0;
            count_next    = '0;
          end else begin
            count_next    = count + CNT_W'(1);
            checksum_next = checksum ^ rx_byte;
          end
        end
        dsfr_pkg::PH_AFTER_DLE: begin
          if (is_dle && !full) begin
            count_next = count + CNT_W'(1);
            phase_next = dsfr_pkg::PH_IN_FRAME;
          end else if (is_etx) begin
            phase_next = dsfr_pkg::PH_AWAIT_SUM;
          end else begin
            phase_next    = dsfr_pkg::PH_IDLE;
            checksum_next = '0;
            count_next    = '0;
          end
        end
        dsfr_pkg::PH_AWAIT_SUM: begin
          phase_next    = dsfr_pkg::PH_IDLE;
          checksum_next = '0;
          count_next    = '0;
        end
        default: begin
          phase_next = is_dle ? dsfr_pkg::PH_AWAIT_STX : dsfr_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    wr_en          = 1'b0;
    wr_addr        = count[ADDR_W-1:0];
    wr_data        = rx_byte;
    q_push         = 1'b0;
    q_cmd.is_burst = 1'b0;
    q_cmd.status   = dsfr_pkg::ST_DATA;
    q_cmd.count    = dsfr_pkg::LIMIT_W'(count);
    if (accept) begin
      case (phase)
        dsfr_pkg::PH_IN_FRAME: begin
          if (!is_dle) begin
            if (full) begin
              q_push       = 1'b1;
              q_cmd.status = dsfr_pkg::ST_OVERFLOW;
            end else begin
              wr_en = 1'b1;
            end
          end
        end
        dsfr_pkg::PH_AFTER_DLE: begin
          if (is_dle) begin
            if (full) begin
              q_push       = 1'b1;
              q_cmd.status = dsfr_pkg::ST_OVERFLOW;
            end else begin
              wr_en   = 1'b1;
              wr_data = dsfr_pkg::CODE_DLE;
            end
          end else if (!is_etx) begin
            q_push       = 1'b1;
            q_cmd.status = dsfr_pkg::ST_BAD_ESC;
          end
        end
        dsfr_pkg::PH_AWAIT_SUM: begin
          q_push = 1'b1;
          if (rx_byte != checksum) begin
            q_cmd.status = dsfr_pkg::ST_MISMATCH;
          end else if (count == '0) begin
            q_cmd.status = dsfr_pkg::ST_EMPTY;
          end else begin
            q_cmd.is_burst = 1'b1;
          end
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= dsfr_pkg::PH_IDLE;
      checksum      <= '0;
      count         <= '0;
      burst_pending <= 1'b0;
    end else begin
      phase    <= phase_next;
      checksum <= checksum_next;
      count    <= count_next;
      if (q_push && q_cmd.is_burst) begin
        burst_pending <= 1'b1;
      end else if (burst_done) begin
        burst_pending <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/dsfr_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO of frame commands between the parser and the emitter.
// ----------------------------------------------------------------------------
module dsfr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dsfr_pkg::cmd_t push_cmd,
  input  logic           pop,
  output dsfr_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);

  dsfr_pkg::cmd_t                entries [dsfr_pkg::QUEUE_DEPTH];
  logic [dsfr_pkg::QPTR_W-1:0]   wr_ptr;
  logic [dsfr_pkg::QPTR_W-1:0]   rd_ptr;
  logic [dsfr_pkg::QCNT_W-1:0]   fill;

  assign head  = entries[rd_ptr];
  assign full  = (fill == dsfr_pkg::QCNT_W'(dsfr_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + dsfr_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + dsfr_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + dsfr_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - dsfr_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/dsfr_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result emitter
// Pops frame commands and drives the result register: one status word, or
// the stored payload read out one word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module dsfr_emit #(
  parameter int PAYLOAD_DEPTH = dsfr_pkg::PAYLOAD_DEPTH,
  parameter int ADDR_W        = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dsfr_pkg::cmd_t                head,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          rd_en,
  output logic [ADDR_W-1:0]             rd_addr,
  input  logic [dsfr_pkg::BYTE_W-1:0]   rd_data,
  output logic                          burst_done,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dsfr_pkg::BYTE_W-1:0]   out_byte,
  output logic                          last_of_frame,
  output logic [dsfr_pkg::STATUS_W-1:0] frame_status
);

  dsfr_pkg::emit_state_t state, state_next;
  logic [ADDR_W-1:0]     cur_addr;
  logic [ADDR_W-1:0]     last_addr;
  logic                  out_free;
  logic                  at_last;
  logic                  load_status;
  logic                  load_data;

  assign out_free = !out_valid || out_ready;
  assign at_last  = (cur_addr == last_addr);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dsfr_pkg::EM_IDLE: begin
        if (!q_empty && head.is_burst) begin
          state_next = dsfr_pkg::EM_LOAD;
        end
      end
      dsfr_pkg::EM_LOAD: begin
        if (out_free && at_last) begin
          state_next = dsfr_pkg::EM_IDLE;
        end
      end
      default: begin
        state_next = dsfr_pkg::EM_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    q_pop       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = cur_addr + ADDR_W'(1);
    load_status = 1'b0;
    load_data   = 1'b0;
    burst_done  = 1'b0;
    case (state)
      dsfr_pkg::EM_IDLE: begin
        if (!q_empty) begin
          if (head.is_burst) begin
            q_pop   = 1'b1;
            rd_en   = 1'b1;
            rd_addr = '0;
          end else if (out_free) begin
            q_pop       = 1'b1;
            load_status = 1'b1;
          end
        end
      end
      dsfr_pkg::EM_LOAD: begin
        if (out_free) begin
          load_data = 1'b1;
          if (at_last) begin
            burst_done = 1'b1;
          end else begin
            rd_en = 1'b1;
          end
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dsfr_pkg::EM_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_status || load_data) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Track the address whose data sits in the read register
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_addr <= rd_addr;
    end
    if (q_pop && head.is_burst) begin
      last_addr <= ADDR_W'(head.count - dsfr_pkg::LIMIT_W'(1));
    end
    if (load_status) begin
      out_byte      <= '0;
      last_of_frame <= 1'b1;
      frame_status  <= head.status;
    end else if (load_data) begin
      out_byte      <= rd_data;
      last_of_frame <= at_last;
      frame_status  <= dsfr_pkg::ST_DATA;
    end
  end

endmodule

/* hw/rtl/dle_stx_frame_receiver_core.sv */
`timescale 1ns / 1ps
// A status result passes through the command queue and the output register; a payload
// burst goes via the queue, RAM read register and output register, then one word per
// cycle while out_ready is high. Input: one byte per cycle while in_ready is high;
// payload bytes of a new frame wait until the previous frame's payload has been read
// out of the one shared payload RAM. Reset clears parser, queue and output valid flag
// and sets the limit to 64; payload RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// DLE STX frame receiver core
// Parses byte-stuffed DLE STX / DLE ETX frames with an XOR checksum and
// emits verified payload or one status word per frame.
// ----------------------------------------------------------------------------
module dle_stx_frame_receiver_core #(
  parameter int PAYLOAD_DEPTH = dsfr_pkg::PAYLOAD_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dsfr_pkg::BYTE_W-1:0]   rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dsfr_pkg::BYTE_W-1:0]   out_byte,
  output logic                          last_of_frame,
  output logic [dsfr_pkg::STATUS_W-1:0] frame_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dsfr_pkg::LIMIT_W-1:0]  cfg_data
);

  localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int CNT_W  = $clog2(PAYLOAD_DEPTH + 1);

  logic [dsfr_pkg::LIMIT_W-1:0] payload_limit;
  logic                         q_full, q_empty, q_push, q_pop;
  dsfr_pkg::cmd_t               q_cmd, q_head;
  logic                         burst_done;
  logic                         wr_en, rd_en;
  logic [ADDR_W-1:0]            wr_addr, rd_addr;
  logic [dsfr_pkg::BYTE_W-1:0]  wr_data, rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit <= dsfr_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      payload_limit <= cfg_data;
    end
  end

  dsfr_parser #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
    .ADDR_W        (ADDR_W),
    .CNT_W         (CNT_W)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .payload_limit (payload_limit),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd),
    .burst_done    (burst_done),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  dsfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  dsfr_ram #(
    .WIDTH  (dsfr_pkg::BYTE_W),
    .DEPTH  (PAYLOAD_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dsfr_emit #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
    .ADDR_W        (ADDR_W)
  ) u_emit (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .burst_done    (burst_done),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last_of_frame (last_of_frame),
    .frame_status  (frame_status)
  );

endmodule
